[design/pwqe_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the PostgreSQL front-end query extractor.
// No dependencies; every other file imports this package.
package pwqe_pkg;

   localparam logic [31:0] SSL_REQUEST_CODE   = 32'd80877103;
   localparam logic [31:0] LENGTH_SELF_BYTES  = 32'd4;
   localparam logic [31:0] STARTUP_SSL_LENGTH = LENGTH_SELF_BYTES + 32'd4;

   localparam logic [7:0] QUERY_TYPE_RESET = 8'd81;
   localparam logic [7:0] PARSE_TYPE_RESET = 8'd80;

   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUERY_TYPE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARSE_TYPE = 8'd1;

   localparam logic [1:0] LEN_LAST_INDEX = 2'd3;

   localparam logic KIND_QUERY = 1'b0;
   localparam logic KIND_PARSE = 1'b1;

   localparam int RSP_TDATA_W = 48;

   typedef enum logic [2:0] {
      PH_LEN  = 3'b001,
      PH_TYPE = 3'b010,
      PH_DATA = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0]  text_byte;
      logic        byte_valid;
      logic [31:0] zeros_before;
      logic        message_kind;
      logic        end_of_message;
   } result_type;

endpackage

[design/pwqe_parser.sv]
`timescale 1ns / 1ps
// Input register and deframing state machine: startup, type, length and payload.
// Depends on pwqe_pkg.
module pwqe_parser
   import pwqe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic [7:0] in_byte,
   output logic       in_ready,
   input  logic [7:0] query_code,
   input  logic [7:0] parse_code,
   input  logic       out_room,
   output logic       res_valid,
   output result_type res
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        step;

   phase_type   phase_ff, phase_in;
   logic        in_startup_ff, in_startup_in;
   logic [1:0]  len_idx_ff, len_idx_in;
   logic [31:0] length_shift_ff, length_shift_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [7:0]  current_type_ff, current_type_in;
   logic [31:0] startup_code_ff, startup_code_in;
   logic        seen_nonzero_ff, seen_nonzero_in;
   logic [31:0] zero_run_ff, zero_run_in;

   logic [31:0] full_len;
   logic [31:0] payload_len;
   logic [31:0] code_next;
   logic        last_byte;
   logic        is_query;
   logic        is_parse;

   assign step     = in_valid_ff && out_room;
   assign in_ready = !in_valid_ff || out_room;
   assign in_valid_in = (in_valid && in_ready) || (in_valid_ff && !out_room);

   assign full_len    = (len_idx_ff == 2'd0) ? {24'd0, in_byte_ff}
                                             : {length_shift_ff[23:0], in_byte_ff};
   assign payload_len = (full_len < LENGTH_SELF_BYTES) ? 32'd0
                                                       : full_len - LENGTH_SELF_BYTES;
   assign code_next   = {startup_code_ff[23:0], in_byte_ff};
   assign last_byte   = (remaining_ff == 32'd1);
   assign is_query    = (current_type_ff == query_code);
   assign is_parse    = !is_query && (current_type_ff == parse_code);

   always_comb begin
      phase_in        = phase_ff;
      in_startup_in   = in_startup_ff;
      len_idx_in      = len_idx_ff;
      length_shift_in = length_shift_ff;
      remaining_in    = remaining_ff;
      current_type_in = current_type_ff;
      startup_code_in = startup_code_ff;
      seen_nonzero_in = seen_nonzero_ff;
      zero_run_in     = zero_run_ff;
      res_valid       = 1'b0;
      res             = '0;
      if (step) begin
         case (phase_ff)
            PH_TYPE: begin
               current_type_in = in_byte_ff;
               phase_in        = PH_LEN;
            end
            PH_DATA: begin
               remaining_in = remaining_ff - 32'd1;
               if (in_startup_ff) begin
                  startup_code_in = code_next;
                  if (last_byte) begin
                     if (length_shift_ff == STARTUP_SSL_LENGTH &&
                         code_next == SSL_REQUEST_CODE) begin
                        phase_in = PH_LEN;
                     end else begin
                        in_startup_in = 1'b0;
                        phase_in      = PH_TYPE;
                     end
                  end
               end else begin
                  if (last_byte) begin
                     phase_in = PH_TYPE;
                  end
                  if (is_query) begin
                     res_valid          = 1'b1;
                     res.text_byte      = in_byte_ff;
                     res.byte_valid     = 1'b1;
                     res.message_kind   = KIND_QUERY;
                     res.end_of_message = last_byte;
                  end else if (is_parse) begin
                     if (in_byte_ff == 8'd0) begin
                        if (seen_nonzero_ff) begin
                           zero_run_in = zero_run_ff + 32'd1;
                        end
                        if (last_byte) begin
                           res_valid          = 1'b1;
                           res.message_kind   = KIND_PARSE;
                           res.end_of_message = 1'b1;
                        end
                     end else begin
                        res_valid          = 1'b1;
                        res.text_byte      = in_byte_ff;
                        res.byte_valid     = 1'b1;
                        res.zeros_before   = seen_nonzero_ff ? zero_run_ff : 32'd0;
                        res.message_kind   = KIND_PARSE;
                        res.end_of_message = last_byte;
                        zero_run_in        = 32'd0;
                        seen_nonzero_in    = 1'b1;
                     end
                  end
               end
            end
            default: begin
               length_shift_in = full_len;
               if (len_idx_ff != LEN_LAST_INDEX) begin
                  len_idx_in = len_idx_ff + 2'd1;
               end else begin
                  len_idx_in      = 2'd0;
                  remaining_in    = payload_len;
                  startup_code_in = 32'd0;
                  seen_nonzero_in = 1'b0;
                  zero_run_in     = 32'd0;
                  if (payload_len != 32'd0) begin
                     phase_in = PH_DATA;
                  end else begin
                     phase_in = PH_TYPE;
                     if (in_startup_ff) begin
                        in_startup_in = 1'b0;
                     end else if (is_query || is_parse) begin
                        res_valid          = 1'b1;
                        res.message_kind   = is_query ? KIND_QUERY : KIND_PARSE;
                        res.end_of_message = 1'b1;
                     end
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         in_byte_ff <= in_byte;
      end
      if (reset) begin
         in_valid_ff     <= 1'b0;
         phase_ff        <= PH_LEN;
         in_startup_ff   <= 1'b1;
         len_idx_ff      <= 2'd0;
         length_shift_ff <= 32'd0;
         remaining_ff    <= 32'd0;
         current_type_ff <= 8'd0;
         startup_code_ff <= 32'd0;
         seen_nonzero_ff <= 1'b0;
         zero_run_ff     <= 32'd0;
      end else begin
         in_valid_ff     <= in_valid_in;
         phase_ff        <= phase_in;
         in_startup_ff   <= in_startup_in;
         len_idx_ff      <= len_idx_in;
         length_shift_ff <= length_shift_in;
         remaining_ff    <= remaining_in;
         current_type_ff <= current_type_in;
         startup_code_ff <= startup_code_in;
         seen_nonzero_ff <= seen_nonzero_in;
         zero_run_ff     <= zero_run_in;
      end
   end

   a_data_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (remaining_ff != 32'd0))
      else $error("payload phase with no bytes left");

   a_startup_once: assert property (@(posedge clock) disable iff (reset)
      !in_startup_ff |=> !in_startup_ff)
      else $error("startup parsing re-entered");

   a_len_idx_phase: assert property (@(posedge clock) disable iff (reset)
      (len_idx_ff != 2'd0) |-> (phase_ff == PH_LEN))
      else $error("length byte index outside length phase");

   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res.byte_valid) |->
         (res.end_of_message && res.text_byte == 8'd0 && res.zeros_before == 32'd0))
      else $error("malformed bare end marker");

   a_query_no_zeros: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.message_kind == KIND_QUERY) |-> (res.zeros_before == 32'd0))
      else $error("query result carries held zeros");

   a_no_startup_output: assert property (@(posedge clock) disable iff (reset)
      (res_valid && in_startup_ff) |-> 1'b0)
      else $error("result emitted during startup message");

endmodule

[design/pwqe_out_buf.sv]
`timescale 1ns / 1ps
// Result register with a skid stage in front of the response channel.
// Depends on pwqe_pkg.
module pwqe_out_buf
   import pwqe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       room,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       drain;

   assign room      = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign drain     = !main_valid_ff || out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (drain) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = push;
            skid_in       = push_data;
         end else begin
            main_valid_in = push;
            main_in       = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

endmodule

[design/pg_wire_query_extractor_unit.sv]
`timescale 1ns / 1ps
// Takes one client-to-server stream byte per request and sustains one byte
// per cycle unless the response side stalls: each byte is held in an input
// register, deframed and its result registered in a result register with a
// skid stage; a stalled response side holds the input after two results
// queue up. Query payload bytes pass through; Parse payloads drop leading
// and trailing zeros and report each inner zero run as a count on the next
// nonzero byte. Top level; depends on pwqe_pkg, pwqe_parser and pwqe_out_buf.
module pg_wire_query_extractor_unit
   import pwqe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] stream_byte
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [7:0] text_byte, [8] byte_valid,
                                               // [40:9] zeros_before, zero fill
   output logic                   rsp_tuser,   // [0] message_kind
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   logic [7:0] query_code_ff;
   logic [7:0] parse_code_ff;
   logic       room;
   logic       res_valid;
   result_type res;
   result_type rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         query_code_ff <= QUERY_TYPE_RESET;
         parse_code_ff <= PARSE_TYPE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_QUERY_TYPE: query_code_ff <= csr_data;
            CSR_PARSE_TYPE: parse_code_ff <= csr_data;
            default: ;
         endcase
      end
   end

   pwqe_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_byte    (req_tdata),
      .in_ready   (req_tready),
      .query_code (query_code_ff),
      .parse_code (parse_code_ff),
      .out_room   (room),
      .res_valid  (res_valid),
      .res        (res)
   );

   pwqe_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   assign rsp_tdata = {7'd0, rsp.zeros_before, rsp.byte_valid, rsp.text_byte};
   assign rsp_tuser = rsp.message_kind;
   assign rsp_tlast = rsp.end_of_message;

endmodule

[tb/pg_wire_query_extractor_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for pg_wire_query_extractor_unit: streams startup, query, parse and
// other messages through the request side and checks every result against a deframer
// model kept in the bench. Depends on pwqe_pkg and the RTL of the unit.
module pg_wire_query_extractor_unit_tb;
   import pwqe_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int IDLE_PCT       = 31;
   localparam int RANDOM_BYTES   = 1800;
   localparam int PHASE_COUNT    = 5;
   localparam logic [7:0] SHARED_CODE = 8'h5A;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = 8'd0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_QUERY_TYPE;
   logic [7:0]             csr_data = 8'd0;

   pg_wire_query_extractor_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // deframer state, as after reset
   logic [7:0]  query_code   = QUERY_TYPE_RESET;
   logic [7:0]  parse_code   = PARSE_TYPE_RESET;
   phase_type   frame_phase  = PH_LEN;
   logic        in_startup   = 1'b1;
   logic [1:0]  len_idx      = 2'd0;
   logic [31:0] len_acc      = 32'd0;
   logic [31:0] remaining    = 32'd0;
   logic [7:0]  cur_type     = 8'd0;
   logic [31:0] startup_word = 32'd0;
   logic        seen_nonzero = 1'b0;
   logic [31:0] zero_run     = 32'd0;

   result_type  pending_text[$];
   logic [7:0]  plan_q[$];
   logic [7:0]  stream_q[$];

   int unsigned bytes_fed    = 0;
   int unsigned bytes_taken  = 0;
   int unsigned fail_count   = 0;
   int unsigned quiet_cycles = 0;
   bit          req_taken    = 1'b0;
   bit          csr_taken    = 1'b0;
   bit          calm         = 1'b0;
   result_type  want;
   logic        ok;

   function automatic void expect_text(input logic [7:0] text, input logic valid,
                                       input logic [31:0] zeros, input logic kind,
                                       input logic last);
      result_type r;
      r.text_byte      = text;
      r.byte_valid     = valid;
      r.zeros_before   = zeros;
      r.message_kind   = kind;
      r.end_of_message = last;
      pending_text.push_back(r);
   endfunction

   function automatic void deframe_byte(input logic [7:0] b);
      logic is_query;
      logic is_parse;
      logic last;
      is_query = (cur_type == query_code);
      is_parse = !is_query && (cur_type == parse_code);
      if (frame_phase == PH_TYPE) begin
         cur_type    = b;
         frame_phase = PH_LEN;
      end else if (frame_phase != PH_DATA) begin
         len_acc = (len_idx == 2'd0) ? {24'd0, b} : {len_acc[23:0], b};
         if (len_idx < LEN_LAST_INDEX) begin
            len_idx = len_idx + 2'd1;
         end else begin
            len_idx      = 2'd0;
            remaining    = (len_acc < LENGTH_SELF_BYTES) ? 32'd0 : len_acc - LENGTH_SELF_BYTES;
            startup_word = 32'd0;
            seen_nonzero = 1'b0;
            zero_run     = 32'd0;
            if (remaining != 32'd0) begin
               frame_phase = PH_DATA;
            end else begin
               frame_phase = PH_TYPE;
               if (in_startup)
                  in_startup = 1'b0;
               else if (is_query || is_parse)
                  expect_text(8'd0, 1'b0, 32'd0, is_parse ? KIND_PARSE : KIND_QUERY, 1'b1);
            end
         end
      end else begin
         remaining = remaining - 32'd1;
         last      = (remaining == 32'd0);
         if (in_startup) begin
            startup_word = {startup_word[23:0], b};
            if (last) begin
               if (len_acc == STARTUP_SSL_LENGTH && startup_word == SSL_REQUEST_CODE) begin
                  frame_phase = PH_LEN;
               end else begin
                  in_startup  = 1'b0;
                  frame_phase = PH_TYPE;
               end
            end
         end else begin
            if (last)
               frame_phase = PH_TYPE;
            if (is_query) begin
               expect_text(b, 1'b1, 32'd0, KIND_QUERY, last);
            end else if (is_parse) begin
               if (b == 8'd0) begin
                  if (seen_nonzero)
                     zero_run = zero_run + 32'd1;
                  if (last)
                     expect_text(8'd0, 1'b0, 32'd0, KIND_PARSE, 1'b1);
               end else begin
                  expect_text(b, 1'b1, seen_nonzero ? zero_run : 32'd0, KIND_PARSE, last);
                  zero_run     = 32'd0;
                  seen_nonzero = 1'b1;
               end
            end
         end
      end
   endfunction

   function automatic bit same_field(input string name, input logic [31:0] expected,
                                     input logic [31:0] actual);
      if (expected !== actual)
         $display("%0t %s mismatch: expected %0h actual %0h", $time, name, expected, actual);
      return expected === actual;
   endfunction

   function automatic void put_length(input logic [31:0] len);
      plan_q.push_back(len[31:24]);
      plan_q.push_back(len[23:16]);
      plan_q.push_back(len[15:8]);
      plan_q.push_back(len[7:0]);
   endfunction

   function automatic void put_random_message();
      int unsigned roll;
      int unsigned body;
      int unsigned zero_pct;
      roll = $urandom_range(99);
      case ($urandom_range(5))
         0:       plan_q.push_back(QUERY_TYPE_RESET);
         1:       plan_q.push_back(PARSE_TYPE_RESET);
         2:       plan_q.push_back(8'h00);
         3:       plan_q.push_back(8'hFF);
         4:       plan_q.push_back(SHARED_CODE);
         default: plan_q.push_back(8'($urandom));
      endcase
      if (roll < 10) begin
         put_length($urandom_range(4));
      end else begin
         body     = (roll < 15) ? $urandom_range(80, 40) : $urandom_range(12, 1);
         zero_pct = $urandom_range(3) * 20;
         put_length(body + LENGTH_SELF_BYTES);
         repeat (body) plan_q.push_back(($urandom_range(99) < zero_pct) ? 8'h00 : 8'($urandom));
      end
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] value);
      @(negedge clock);
      csr_taken = 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
   endtask

   task automatic feed_chunk(input int unsigned count);
      repeat (count) begin
         stream_q.push_back(plan_q.pop_front());
         bytes_fed++;
      end
      while (bytes_taken != bytes_fed) @(posedge clock);
      while (pending_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            req_taken = 1'b0;
            if (stream_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= stream_q.pop_front();
            end else begin
               req_tvalid <= 1'b0;
               req_tdata  <= 8'($urandom);
            end
         end
         rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      if (!reset) begin
         quiet_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            quiet_cycles = 0;
            if (pending_text.size() == 0) begin
               $display("%0t unexpected result: expected none, actual tdata %h tuser %b tlast %b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               fail_count++;
            end else begin
               want = pending_text.pop_front();
               ok = same_field("text_byte", {24'd0, want.text_byte}, {24'd0, rsp_tdata[7:0]})
                  & same_field("byte_valid", {31'd0, want.byte_valid}, {31'd0, rsp_tdata[8]})
                  & same_field("zeros_before", want.zeros_before, rsp_tdata[40:9])
                  & same_field("message_kind", {31'd0, want.message_kind}, {31'd0, rsp_tuser})
                  & same_field("end_of_message", {31'd0, want.end_of_message},
                               {31'd0, rsp_tlast})
                  & same_field("tdata fill", 32'd0, {25'd0, rsp_tdata[RSP_TDATA_W-1:41]});
               if (!ok)
                  fail_count++;
            end
         end
         if (req_tvalid && req_tready) begin
            quiet_cycles = 0;
            deframe_byte(req_tdata);
            bytes_taken++;
            req_taken = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            quiet_cycles = 0;
            case (csr_index)
               CSR_QUERY_TYPE: query_code = csr_data;
               CSR_PARSE_TYPE: parse_code = csr_data;
               default: ;
            endcase
            csr_taken = 1'b1;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("pg_wire_query_extractor_unit_tb: FAIL");
            $finish;
         end
      end
   end

   initial begin
      int unsigned chunk;
      // SSL request restarts startup, then a short startup length ends it
      put_length(STARTUP_SSL_LENGTH);
      put_length(SSL_REQUEST_CODE);
      put_length(32'd0);
      // short query length gives a bare end marker
      plan_q.push_back(QUERY_TYPE_RESET);
      put_length(32'd2);
      // parse: leading zero dropped, inner run counted, trailing run dropped
      plan_q.push_back(PARSE_TYPE_RESET);
      put_length(LENGTH_SELF_BYTES + 32'd6);
      plan_q.push_back(8'h00);
      plan_q.push_back(8'h07);
      plan_q.push_back(8'h00);
      plan_q.push_back(8'h00);
      plan_q.push_back(8'hFF);
      plan_q.push_back(8'h00);
      while (plan_q.size() < RANDOM_BYTES + 28)
         put_random_message();
      // open-ended message with the largest length
      plan_q.push_back(8'($urandom));
      put_length(32'hFFFF_FFFF);
      repeat (6) plan_q.push_back(8'($urandom));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      chunk = plan_q.size() / PHASE_COUNT;
      feed_chunk(chunk);
      write_reg(CSR_QUERY_TYPE, 8'h00);
      write_reg(CSR_PARSE_TYPE, 8'hFF);
      feed_chunk(chunk);
      write_reg(CSR_QUERY_TYPE, SHARED_CODE);
      write_reg(CSR_PARSE_TYPE, SHARED_CODE);
      calm = 1'b1;
      feed_chunk(chunk);
      calm = 1'b0;
      write_reg(CSR_QUERY_TYPE, 8'hFF);
      write_reg(CSR_PARSE_TYPE, 8'h00);
      feed_chunk(chunk);
      write_reg(CSR_QUERY_TYPE, QUERY_TYPE_RESET);
      write_reg(CSR_PARSE_TYPE, PARSE_TYPE_RESET);
      feed_chunk(plan_q.size());

      if (fail_count == 0)
         $display("pg_wire_query_extractor_unit_tb: PASS");
      else
         $display("pg_wire_query_extractor_unit_tb: FAIL");
      $finish;
   end

endmodule

[files.f]
design/pwqe_pkg.sv
design/pwqe_parser.sv
design/pwqe_out_buf.sv
design/pg_wire_query_extractor_unit.sv
tb/pg_wire_query_extractor_unit_tb.sv
